>>> rtl/core/etp_pkg.sv
// shared types and constants of the exclusive time profiler
`default_nettype none

package etp_pkg;

   // largest exclusive total, totals saturate here
   localparam logic [30:0] TOTAL_MAX = 31'h7FFF_FFFF;

   // largest value shown on the stack depth port
   localparam int DEPTH_OUT_MAX = 127;

   // per-event status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_BACKWARD  = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_RESUME
   } state_type;

   // one word of the per-function memory
   typedef struct packed {
      logic [31:0] resume;
      logic [30:0] total;
   } func_entry_type;

endpackage

`default_nettype wire

>>> rtl/core/exclusive_time_profiler_unit.sv
// top level of the exclusive time profiler: call stack and per-function totals
// ---------------------------------------------------------------------------
// usage
//   req_* carries one trace event (function id, start or end, timestamp) per
//   request; rsp_* returns one result per event: which total changed, its new
//   saturated value, the stack depth after the event and a status code.
//   a request is taken when valid is high and stall is low, on either side.
// result path
//   an accepted event is latched; exec then writes its result into the output
//   register once it is free. a start, an end that empties the stack, and any
//   dropped or ignored event go back to idle from exec; an end that leaves a
//   parent passes through resume for its resume-time write on the single
//   write port of the function memory. a new request is taken only in idle.
// reset
//   synchronous, active high. afterwards a clearing pass zeroes the function
//   memory, one entry per cycle, with req_stall held high.
// receiver stall
//   a result waits in the output register; one more request may be accepted
//   and read meanwhile, but its total update waits until the register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module exclusive_time_profiler_unit #(
   parameter int NUM_FUNCS   = 64,
   parameter int STACK_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // event requests
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [5:0]  req_func_id,
   input  wire logic        req_is_start,
   input  wire logic [30:0] req_timestamp,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_changed,
   output logic [5:0]       rsp_changed_id,
   output logic [30:0]      rsp_new_total,
   output logic [6:0]       rsp_stack_depth,
   output logic [1:0]       rsp_status
);

   localparam int FAW  = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
   localparam int IdW  = (FAW < 6) ? FAW : 6;
   localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CntW = $clog2(STACK_DEPTH + 1);

   // id reduction table, built at elaboration
   logic [IdW-1:0] id_tbl [64];
   for (genvar g = 0; g < 64; g++) begin : g_id_tbl
      assign id_tbl[g] = IdW'(g % NUM_FUNCS);
   end

   // memories
   etp_pkg::func_entry_type func_mem [NUM_FUNCS];
   logic [IdW-1:0]          stack_mem [STACK_DEPTH];

   // control state
   etp_pkg::state_type state_ff, state_in;
   logic [FAW-1:0]     clr_ff, clr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [IdW-1:0]     top_ff, top_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // latched event
   logic               op_charge_ff, op_inc_ff, op_parent_ff;
   logic [IdW-1:0]     op_addr_ff;
   logic [30:0]        op_time_ff;
   logic [6:0]         op_depth_ff;
   etp_pkg::status_type op_status_ff;

   // memory read data
   etp_pkg::func_entry_type fr_data_ff;
   logic [IdW-1:0]          sr_data_ff;

   // result register
   logic                rsp_changed_ff;
   logic [5:0]          rsp_changed_id_ff;
   logic [30:0]         rsp_new_total_ff;
   logic [6:0]          rsp_stack_depth_ff;
   etp_pkg::status_type rsp_status_ff;

   // memory port controls
   logic           fw_total_en, fw_resume_en, fr_en, sw_en, sr_en;
   logic [FAW-1:0] fw_addr, fr_addr;
   logic [30:0]    fw_total;
   logic [31:0]    fw_resume;
   logic [SAW-1:0] sw_addr, sr_addr;

   // decode of the incoming event
   logic           accept, st_full, st_empty, out_free, exec_go;
   logic [IdW-1:0] req_id;
   logic [CntW-1:0] count_m2, next_count;
   logic [6:0]     next_depth;

   assign req_stall = (state_ff != etp_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign st_full   = (count_ff >= CntW'(STACK_DEPTH));
   assign st_empty  = (count_ff == '0);
   assign req_id    = id_tbl[req_func_id];
   assign count_m2  = count_ff - CntW'(2);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign exec_go   = (state_ff == etp_pkg::ST_EXEC) && out_free;

   // stack depth after the event, saturated for the port
   always_comb begin
      next_count = count_ff;
      if (req_is_start && !st_full) begin
         next_count = count_ff + CntW'(1);
      end else if (!req_is_start && !st_empty) begin
         next_count = count_ff - CntW'(1);
      end
      next_depth = (32'(next_count) > 32'(etp_pkg::DEPTH_OUT_MAX)) ?
                   7'(etp_pkg::DEPTH_OUT_MAX) : 7'(next_count);
   end

   // charge arithmetic: total + (t - resume + inc), clamped and saturated
   logic        back;
   logic [33:0] sum;
   logic [30:0] sat_total;

   always_comb begin
      back = ({1'b0, op_time_ff} < fr_data_ff.resume);
      sum  = {3'b0, fr_data_ff.total} + {3'b0, op_time_ff}
           - {2'b0, fr_data_ff.resume} + {33'b0, op_inc_ff};
      if (back) begin
         sat_total = fr_data_ff.total;
      end else if (sum > {3'b0, etp_pkg::TOTAL_MAX}) begin
         sat_total = etp_pkg::TOTAL_MAX;
      end else begin
         sat_total = sum[30:0];
      end
   end

   // sequencer: next state and memory controls
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      fw_total_en  = 1'b0;
      fw_resume_en = 1'b0;
      fw_addr      = FAW'(op_addr_ff);
      fw_total     = sat_total;
      fw_resume    = {1'b0, req_timestamp};
      fr_en        = 1'b0;
      fr_addr      = FAW'(top_ff);
      sw_en        = 1'b0;
      sw_addr      = count_ff[SAW-1:0];
      sr_en        = 1'b0;
      sr_addr      = count_m2[SAW-1:0];
      unique case (state_ff)
         etp_pkg::ST_CLEAR: begin
            fw_total_en  = 1'b1;
            fw_resume_en = 1'b1;
            fw_addr      = clr_ff;
            fw_total     = '0;
            fw_resume    = '0;
            clr_in       = clr_ff + FAW'(1);
            if (clr_ff == FAW'(NUM_FUNCS - 1)) begin
               state_in = etp_pkg::ST_IDLE;
            end
         end
         etp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = etp_pkg::ST_EXEC;
               count_in = next_count;
               if (req_is_start && !st_full) begin
                  // push, record the start, read the current top
                  sw_en        = 1'b1;
                  fw_resume_en = 1'b1;
                  fw_addr      = FAW'(req_id);
                  fr_en        = !st_empty;
                  top_in       = req_id;
               end else if (!req_is_start && !st_empty) begin
                  // read the ended function and the parent below the top
                  fr_en   = 1'b1;
                  fr_addr = FAW'(req_id);
                  sr_en   = (count_ff > CntW'(1));
               end
            end
         end
         etp_pkg::ST_EXEC: begin
            if (out_free) begin
               fw_total_en = op_charge_ff;
               state_in    = op_parent_ff ? etp_pkg::ST_RESUME : etp_pkg::ST_IDLE;
            end
         end
         etp_pkg::ST_RESUME: begin
            // parent resumes on the tick after the end
            fw_resume_en = 1'b1;
            fw_addr      = FAW'(sr_data_ff);
            fw_resume    = {1'b0, op_time_ff} + 32'd1;
            top_in       = sr_data_ff;
            state_in     = etp_pkg::ST_IDLE;
         end
         default: begin
            state_in = etp_pkg::ST_IDLE;
         end
      endcase
   end

   // output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // top-of-stack cache
   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // latch the accepted event
   always_ff @(posedge clock) begin
      if (accept) begin
         op_time_ff   <= req_timestamp;
         op_depth_ff  <= next_depth;
         op_inc_ff    <= !req_is_start;
         op_parent_ff <= !req_is_start && (count_ff > CntW'(1));
         op_addr_ff   <= req_is_start ? top_ff : req_id;
         op_charge_ff <= req_is_start ? (!st_full && !st_empty) : !st_empty;
         if (req_is_start && st_full) begin
            op_status_ff <= etp_pkg::STATUS_FULL;
         end else if (!req_is_start && st_empty) begin
            op_status_ff <= etp_pkg::STATUS_UNDERFLOW;
         end else begin
            op_status_ff <= etp_pkg::STATUS_OK;
         end
      end
   end

   // function memory: one write port with field enables, one read port
   always_ff @(posedge clock) begin
      if (fw_total_en) begin
         func_mem[fw_addr].total <= fw_total;
      end
      if (fw_resume_en) begin
         func_mem[fw_addr].resume <= fw_resume;
      end
      if (fr_en) begin
         fr_data_ff <= func_mem[fr_addr];
      end
   end

   // call stack memory
   always_ff @(posedge clock) begin
      if (sw_en) begin
         stack_mem[sw_addr] <= req_id;
      end
      if (sr_en) begin
         sr_data_ff <= stack_mem[sr_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_changed_ff     <= op_charge_ff;
         rsp_changed_id_ff  <= op_charge_ff ? 6'(op_addr_ff) : 6'd0;
         rsp_new_total_ff   <= op_charge_ff ? sat_total : 31'd0;
         rsp_stack_depth_ff <= op_depth_ff;
         if (op_charge_ff && back) begin
            rsp_status_ff <= etp_pkg::STATUS_BACKWARD;
         end else begin
            rsp_status_ff <= op_status_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_changed     = rsp_changed_ff;
   assign rsp_changed_id  = rsp_changed_id_ff;
   assign rsp_new_total   = rsp_new_total_ff;
   assign rsp_stack_depth = rsp_stack_depth_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

>>> rtl/core/etp_checker.sv
// port-level checks of the exclusive time profiler and their bind
`default_nettype none

module etp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_changed,
   input wire logic [5:0]  rsp_changed_id,
   input wire logic [30:0] rsp_new_total,
   input wire logic [6:0]  rsp_stack_depth,
   input wire logic [1:0]  rsp_status
);

   // clearing pass keeps requests out right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during clearing pass");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_new_total) && $stable(rsp_changed_id)
                                 && $stable(rsp_status))
      else $error("result changed while stalled");

   // no update reported means zero id and zero total
   a_no_change_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_changed |-> rsp_changed_id == 6'd0 && rsp_new_total == 31'd0)
      else $error("unchanged result carries data");

   // dropped or ignored events never charge, clamped ones always do, underflow shows depth zero
   a_status_charge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_status == etp_pkg::STATUS_FULL || rsp_status == etp_pkg::STATUS_UNDERFLOW)
            ? !rsp_changed : 1'b1)
         && (rsp_status == etp_pkg::STATUS_BACKWARD ? rsp_changed : 1'b1)
         && (rsp_status == etp_pkg::STATUS_UNDERFLOW ? rsp_stack_depth == 7'd0 : 1'b1))
      else $error("status and charge disagree");

endmodule

bind exclusive_time_profiler_unit etp_checker u_etp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_changed     (rsp_changed),
   .rsp_changed_id  (rsp_changed_id),
   .rsp_new_total   (rsp_new_total),
   .rsp_stack_depth (rsp_stack_depth),
   .rsp_status      (rsp_status)
);

`default_nettype wire

>>> tb/sv/tb_exclusive_time_profiler_unit.sv
// self-checking testbench for the exclusive time profiler: call-stack events against a predictor
`default_nettype none

module tb_exclusive_time_profiler_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_FUNCS   = 64;
   localparam int STACK_DEPTH = 64;
   localparam int IDLE_LIMIT  = 5000;
   localparam int TAIL_CYCLES = 20;

   // one trace event as sent on the request channel
   typedef struct packed {
      logic [5:0]  func_id;
      logic        is_start;
      logic [30:0] timestamp;
   } trace_event_type;

   // one result as returned on the response channel
   typedef struct packed {
      logic                changed;
      logic [5:0]          changed_id;
      logic [30:0]         new_total;
      logic [6:0]          stack_depth;
      etp_pkg::status_type status;
   } profile_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [5:0]  req_func_id = '0;
   logic        req_is_start = 1'b0;
   logic [30:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_changed;
   logic [5:0]  rsp_changed_id;
   logic [30:0] rsp_new_total;
   logic [6:0]  rsp_stack_depth;
   logic [1:0]  rsp_status;

   exclusive_time_profiler_unit #(
      .NUM_FUNCS  (NUM_FUNCS),
      .STACK_DEPTH(STACK_DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func_id    (req_func_id),
      .req_is_start   (req_is_start),
      .req_timestamp  (req_timestamp),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_changed    (rsp_changed),
      .rsp_changed_id (rsp_changed_id),
      .rsp_new_total  (rsp_new_total),
      .rsp_stack_depth(rsp_stack_depth),
      .rsp_status     (rsp_status)
   );

   // request and result stores
   trace_event_type    pending_events[$];
   profile_result_type want_results[$];
   int                 fail_count = 0;

   // predictor state: per-function totals and resume times, the call stack
   logic [30:0] excl_total[NUM_FUNCS];
   logic [31:0] resume_at[NUM_FUNCS];
   logic [5:0]  call_ids[STACK_DEPTH];
   int          open_calls = 0;

   // stimulus-side view of the stack, kept in step with the predictor rules
   logic [5:0]  plan_stack[$];
   logic [30:0] plan_time = '0;

   initial begin
      for (int i = 0; i < NUM_FUNCS; i++) begin
         excl_total[i] = '0;
         resume_at[i]  = '0;
      end
   end

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // saturating add of an interval onto a total
   function automatic logic [30:0] sat_add(logic [30:0] total, logic [63:0] span);
      logic [63:0] sum;
      sum = 64'(total) + span;
      return (sum > 64'(etp_pkg::TOTAL_MAX)) ? etp_pkg::TOTAL_MAX : sum[30:0];
   endfunction

   // apply one event to the predictor state and return its result
   function automatic profile_result_type charge_event(trace_event_type ev);
      profile_result_type r;
      logic [5:0]         fid;
      logic [5:0]         top;
      logic [31:0]        t32;
      logic [63:0]        span;
      r = '0;
      r.status = etp_pkg::STATUS_OK;
      fid = ev.func_id;
      t32 = {1'b0, ev.timestamp};
      span = '0;
      if (ev.is_start) begin
         if (open_calls >= STACK_DEPTH) begin
            r.status = etp_pkg::STATUS_FULL;
         end else begin
            // the running function stops accruing at t
            if (open_calls > 0) begin
               top = call_ids[open_calls - 1];
               if (t32 < resume_at[top]) r.status = etp_pkg::STATUS_BACKWARD;
               else span = 64'(t32) - 64'(resume_at[top]);
               excl_total[top] = sat_add(excl_total[top], span);
               r.changed    = 1'b1;
               r.changed_id = top;
               r.new_total  = excl_total[top];
            end
            call_ids[open_calls] = fid;
            open_calls++;
            resume_at[fid] = t32;
         end
      end else begin
         if (open_calls == 0) begin
            r.status = etp_pkg::STATUS_UNDERFLOW;
         end else begin
            // inclusive interval for the named function, then pop
            if (t32 < resume_at[fid]) r.status = etp_pkg::STATUS_BACKWARD;
            else span = 64'(t32) - 64'(resume_at[fid]) + 64'd1;
            excl_total[fid] = sat_add(excl_total[fid], span);
            r.changed    = 1'b1;
            r.changed_id = fid;
            r.new_total  = excl_total[fid];
            open_calls--;
            if (open_calls > 0) resume_at[call_ids[open_calls - 1]] = t32 + 32'd1;
         end
      end
      r.stack_depth = 7'(open_calls);
      return r;
   endfunction

   // queue one request and track the stack it leads to
   task automatic plan_event(logic [5:0] id, logic st, logic [30:0] t);
      trace_event_type ev;
      ev.func_id   = id;
      ev.is_start  = st;
      ev.timestamp = t;
      pending_events = {pending_events, ev};
      if (st && plan_stack.size() < STACK_DEPTH) plan_stack = {plan_stack, id};
      else if (!st && plan_stack.size() > 0) plan_stack.delete(plan_stack.size() - 1);
   endtask

   // the id that a well-formed end would name
   function automatic logic [5:0] plan_top();
      return (plan_stack.size() > 0) ? plan_stack[$] : 6'($urandom_range(0, 63));
   endfunction

   // push past a full stack, then unwind past empty
   task automatic plan_fill_and_unwind();
      for (int i = 0; i < STACK_DEPTH + 3; i++) begin
         plan_time += 31'($urandom_range(0, 3));
         plan_event(6'($urandom_range(0, 63)), 1'b1, plan_time);
      end
      for (int i = 0; i < STACK_DEPTH + 2; i++) begin
         plan_time += 31'($urandom_range(0, 3));
         plan_event(plan_top(), 1'b0, plan_time);
      end
   endtask

   // mostly well-formed nesting with random content, some noise
   task automatic plan_random(int count);
      int pick;
      int d;
      logic st;
      logic [5:0] id;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            plan_event(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 31'($urandom()));
         end else begin
            // time moves on: small steps, jumps, rebase, backward
            pick = $urandom_range(0, 99);
            if (pick < 80) plan_time += 31'($urandom_range(0, 4));
            else if (pick < 92) plan_time += 31'($urandom_range(5, 5000));
            else if (pick < 97) plan_time = 31'($urandom());
            else plan_time -= 31'($urandom_range(1, 20));
            d = plan_stack.size();
            if (d == 0) st = ($urandom_range(0, 99) < 97);
            else if (d >= STACK_DEPTH) st = 1'b0;
            else st = ($urandom_range(0, 99) < ((d < 8) ? 55 : 45));
            if (st) id = 6'($urandom_range(0, 63));
            else id = ($urandom_range(0, 99) < 92) ? plan_top() : 6'($urandom_range(0, 63));
            plan_event(id, st, plan_time);
         end
      end
   endtask

   // hold the stimulus until everything sent has come back
   task automatic drain();
      while (!(pending_events.size() == 0 && !req_valid && want_results.size() == 0))
         @(posedge clock);
   endtask

   // request driver with bursts and gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_proc
      trace_event_type sent;
      trace_event_type ev;
      logic take;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take = req_valid && !req_stall;
         if (take) begin
            sent.func_id   = req_func_id;
            sent.is_start  = req_is_start;
            sent.timestamp = req_timestamp;
            want_results = {want_results, charge_event(sent)};
         end
         if (!req_valid || take) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
               ev = pending_events.pop_front();
               req_valid     <= 1'b1;
               req_func_id   <= ev.func_id;
               req_is_start  <= ev.is_start;
               req_timestamp <= ev.timestamp;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result checker and receiver stall pattern
   int stall_mode = 0;
   int stall_run  = 0;

   always @(posedge clock) begin : check_proc
      profile_result_type want;
      logic s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (want_results.size() == 0) begin
            $error("result with no request outstanding: changed_id %0d new_total %0d",
                   rsp_changed_id, rsp_new_total);
            fail_count++;
         end else begin
            want = want_results.pop_front();
            if (rsp_changed !== want.changed) begin
               $error("changed: expected %0d, got %0d", want.changed, rsp_changed);
               fail_count++;
            end
            if (rsp_changed_id !== want.changed_id) begin
               $error("changed_id: expected %0d, got %0d", want.changed_id, rsp_changed_id);
               fail_count++;
            end
            if (rsp_new_total !== want.new_total) begin
               $error("new_total: expected %0d, got %0d", want.new_total, rsp_new_total);
               fail_count++;
            end
            if (rsp_stack_depth !== want.stack_depth) begin
               $error("stack_depth: expected %0d, got %0d", want.stack_depth, rsp_stack_depth);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
         end
      end
      // stall modes: none, coin flip, solid, sparse
      if (stall_run > 0) begin
         stall_run--;
      end else begin
         stall_mode = $urandom_range(0, 3);
         stall_run  = $urandom_range(5, 60);
      end
      case (stall_mode)
         0: s = 1'b0;
         1: s = 1'($urandom_range(0, 1));
         2: s = 1'b1;
         default: s = ($urandom_range(0, 7) == 0);
      endcase
      rsp_stall <= s;
   end

   // watchdog on cycles with no handshake on either side
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // sequence: reset, directed events, random phases with full pauses
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // end on empty stack
      plan_event(6'd5, 1'b0, 31'd100);
      // start on empty stack, nested start, end of the top
      plan_event(6'd0, 1'b1, 31'd0);
      plan_event(6'd63, 1'b1, 31'd10);
      plan_event(6'd63, 1'b0, 31'd20);
      // start before the parent's resume time: backward
      plan_event(6'd7, 1'b1, 31'd15);
      // end of a function that is not on top
      plan_event(6'd3, 1'b0, 31'd30);
      // end at the largest timestamp, empties the stack
      plan_event(6'd0, 1'b0, etp_pkg::TOTAL_MAX);
      // one call spanning the whole range: total saturates
      plan_event(6'd42, 1'b1, 31'd0);
      plan_event(6'd42, 1'b0, etp_pkg::TOTAL_MAX);
      // saturated total charged again
      plan_event(6'd42, 1'b1, 31'd0);
      plan_event(6'd1, 1'b1, etp_pkg::TOTAL_MAX);
      plan_event(6'd1, 1'b0, etp_pkg::TOTAL_MAX);
      // parent resumes one past the largest timestamp, then ends earlier
      plan_event(6'd42, 1'b0, 31'd5);
      plan_event(6'd63, 1'b0, etp_pkg::TOTAL_MAX);
      // zero-length calls at the same tick
      plan_event(6'd21, 1'b1, 31'd40);
      plan_event(6'd42, 1'b1, 31'd40);
      plan_event(6'd42, 1'b0, 31'd40);
      plan_event(6'd21, 1'b0, 31'd40);
      plan_time = 31'd50;
      drain();

      plan_fill_and_unwind();
      plan_random(500);
      drain();
      plan_random(600);
      drain();
      plan_fill_and_unwind();
      plan_random(500);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
